/* hdl/cfglex_pkg.sv */
// Shared types, constants and helper functions of the config text lexer.
`default_nettype none
package cfglex_pkg;

	localparam int TextLimit = 256;
	localparam int PosW = 16;
	localparam int LenW = $clog2(TextLimit + 2);
	localparam int QueueDepth = 4;
	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam int RunW = 3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_L = 8'h6C;
	localparam logic [7:0] CH_LOWER_R = 8'h72;
	localparam logic [7:0] CH_LOWER_S = 8'h73;
	localparam logic [7:0] CH_LOWER_T = 8'h74;
	localparam logic [7:0] CH_LOWER_U = 8'h75;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_HIGH = 8'h80;

	typedef enum logic [3:0] {
		KIND_WORD = 4'd0,
		KIND_TEXT = 4'd1,
		KIND_NUMBER = 4'd2,
		KIND_TRUE = 4'd3,
		KIND_FALSE = 4'd4,
		KIND_LB = 4'd5,
		KIND_LB2 = 4'd6,
		KIND_RB = 4'd7,
		KIND_RB2 = 4'd8,
		KIND_EQ = 4'd9,
		KIND_DOT = 4'd10,
		KIND_COMMA = 4'd11,
		KIND_EOF = 4'd12,
		KIND_ERROR = 4'd13
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_HASH = 2'd1,
		ERR_BYTE = 2'd2,
		ERR_LONG = 2'd3
	} err_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] char_out;
		logic char_valid;
		logic [31:0] number_value;
		logic [PosW-1:0] token_line;
		logic [PosW-1:0] token_column;
		err_t error_code;
		logic last;
	} res_t;

	// One queue entry holds every result of one byte: a keyword prefix run, then a and b.
	typedef struct packed {
		logic [RunW-1:0] run_cnt;
		logic run_false;
		logic run_last;
		logic [PosW-1:0] run_line;
		logic [PosW-1:0] run_col;
		logic a_valid;
		res_t a;
		logic b_valid;
		res_t b;
	} entry_t;

	function automatic res_t mk_res(input kind_t kind, input logic [7:0] ch,
		input logic valid, input logic [31:0] num, input logic [PosW-1:0] line,
		input logic [PosW-1:0] col, input err_t err, input logic last);
		res_t r;
		r.kind = kind;
		r.char_out = ch;
		r.char_valid = valid;
		r.number_value = num;
		r.token_line = line;
		r.token_column = col;
		r.error_code = err;
		r.last = last;
		return r;
	endfunction

	function automatic logic [7:0] kw_char(input logic is_false, input logic [RunW-1:0] idx);
		logic [7:0] ch;
		ch = CH_NUL;
		if (is_false) begin
			case (idx)
				3'd0: ch = CH_LOWER_F;
				3'd1: ch = CH_LOWER_A;
				3'd2: ch = CH_LOWER_L;
				3'd3: ch = CH_LOWER_S;
				3'd4: ch = CH_LOWER_E;
				default: ch = CH_NUL;
			endcase
		end else begin
			case (idx)
				3'd0: ch = CH_LOWER_T;
				3'd1: ch = CH_LOWER_R;
				3'd2: ch = CH_LOWER_U;
				3'd3: ch = CH_LOWER_E;
				default: ch = CH_NUL;
			endcase
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

/* hdl/cfglex_byte_if.sv */
// Handshake channel that carries one document byte per item.
`default_nettype none
interface cfglex_byte_if;
	logic valid;
	logic ready;
	logic [7:0] byte_in;

	modport source(output valid, output byte_in, input ready);
	modport sink(input valid, input byte_in, output ready);
endinterface
`default_nettype wire

/* hdl/cfglex_token_if.sv */
// Handshake channel that carries one token result per item.
`default_nettype none
interface cfglex_token_if;
	logic valid;
	logic ready;
	logic [3:0] kind;
	logic [7:0] char_out;
	logic char_valid;
	logic [31:0] number_value;
	logic [cfglex_pkg::PosW-1:0] token_line;
	logic [cfglex_pkg::PosW-1:0] token_column;
	logic [1:0] error_code;
	logic last;

	modport source(output valid, output kind, output char_out, output char_valid,
		output number_value, output token_line, output token_column,
		output error_code, output last, input ready);
	modport sink(input valid, input kind, input char_out, input char_valid,
		input number_value, input token_line, input token_column,
		input error_code, input last, output ready);
endinterface
`default_nettype wire

/* hdl/cfglex_front.sv */
// Lexer front end: one byte per cycle unless full; updates lexer state, queues its results.
`default_nettype none
module cfglex_front (
	input logic clk,
	input logic arst_n,
	cfglex_byte_if.sink doc,
	input logic full,
	output logic push,
	output cfglex_pkg::entry_t entry
);

	typedef enum logic [3:0] {
		M_IDLE,
		M_COMMENT,
		M_LBRACK,
		M_RBRACK,
		M_WORD,
		M_TEXT,
		M_NUMBER,
		M_KW_TRUE,
		M_KW_FALSE,
		M_HALT
	} mode_t;

	localparam logic [cfglex_pkg::PosW-1:0] PosOne = cfglex_pkg::PosW'(1);
	localparam logic [cfglex_pkg::PosW-1:0] PosMax = '1;
	localparam logic [cfglex_pkg::LenW-1:0] LenLimit = cfglex_pkg::LenW'(cfglex_pkg::TextLimit);

	mode_t mode_q, mode_d;
	logic [cfglex_pkg::RunW-1:0] prefix_q, prefix_d;
	logic [cfglex_pkg::LenW-1:0] len_q, len_d;
	logic [31:0] acc_q, acc_d;
	logic [cfglex_pkg::PosW-1:0] line_q, line_d, col_q, col_d;
	logic [cfglex_pkg::PosW-1:0] sline_q, sline_d, scol_q, scol_d;
	logic [7:0] held_q, held_d;

	logic accept;
	logic again;
	logic [7:0] c;
	logic [3:0] digit;
	logic kw_is_false;
	logic [cfglex_pkg::RunW-1:0] kw_len;
	logic [cfglex_pkg::RunW-1:0] pm;
	logic cont;
	logic [cfglex_pkg::LenW-1:0] newlen;
	cfglex_pkg::entry_t e;

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= cfglex_pkg::CH_ZERO && ch <= cfglex_pkg::CH_NINE;
	endfunction

	function automatic logic is_alpha(input logic [7:0] ch);
		return (ch >= cfglex_pkg::CH_LOWER_A && ch <= cfglex_pkg::CH_LOWER_Z) ||
			(ch >= cfglex_pkg::CH_UPPER_A && ch <= cfglex_pkg::CH_UPPER_Z);
	endfunction

	function automatic logic is_key(input logic [7:0] ch);
		return ch >= cfglex_pkg::CH_HIGH || is_alpha(ch) || is_digit(ch) ||
			ch == cfglex_pkg::CH_UNDERSCORE || ch == cfglex_pkg::CH_MINUS;
	endfunction

	function automatic logic [cfglex_pkg::PosW-1:0] sat_inc(
		input logic [cfglex_pkg::PosW-1:0] v);
		return (v == PosMax) ? v : v + PosOne;
	endfunction

	assign doc.ready = !full;
	assign accept = doc.valid && !full;
	assign entry = e;
	assign push = accept && (e.run_cnt != '0 || e.a_valid || e.b_valid);

	always_comb begin
		c = doc.byte_in;
		digit = c[3:0];
		mode_d = mode_q;
		prefix_d = prefix_q;
		len_d = len_q;
		acc_d = acc_q;
		line_d = line_q;
		col_d = col_q;
		sline_d = sline_q;
		scol_d = scol_q;
		held_d = held_q;
		e = '0;
		again = 1'b0;
		kw_is_false = (mode_q == M_KW_FALSE);
		kw_len = kw_is_false ? cfglex_pkg::RunW'(5) : cfglex_pkg::RunW'(4);
		pm = prefix_q;
		if (pm == '0 || pm >= kw_len) begin
			pm = cfglex_pkg::RunW'(1);
		end
		cont = is_key(c);
		newlen = '0;

		case (mode_q)
			M_IDLE: begin
				again = 1'b1;
			end
			M_COMMENT: begin
				if (c == cfglex_pkg::CH_LF) begin
					line_d = sat_inc(line_q);
					col_d = PosOne;
					mode_d = M_IDLE;
				end else if (c == cfglex_pkg::CH_NUL) begin
					mode_d = M_IDLE;
					again = 1'b1;
				end else begin
					col_d = sat_inc(col_q);
				end
			end
			M_LBRACK, M_RBRACK: begin
				e.a_valid = 1'b1;
				mode_d = M_IDLE;
				if (c == ((mode_q == M_LBRACK) ? cfglex_pkg::CH_LBRACK : cfglex_pkg::CH_RBRACK))
				begin
					e.a = cfglex_pkg::mk_res((mode_q == M_LBRACK) ? cfglex_pkg::KIND_LB2 :
						cfglex_pkg::KIND_RB2, 8'd0, 1'b0, 32'd0, sline_q, scol_q,
						cfglex_pkg::ERR_NONE, 1'b1);
					col_d = sat_inc(col_q);
				end else begin
					e.a = cfglex_pkg::mk_res((mode_q == M_LBRACK) ? cfglex_pkg::KIND_LB :
						cfglex_pkg::KIND_RB, 8'd0, 1'b0, 32'd0, sline_q, scol_q,
						cfglex_pkg::ERR_NONE, 1'b1);
					again = 1'b1;
				end
			end
			M_NUMBER: begin
				if (is_digit(c)) begin
					acc_d = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, digit};
					col_d = sat_inc(col_q);
				end else begin
					e.a_valid = 1'b1;
					e.a = cfglex_pkg::mk_res(cfglex_pkg::KIND_NUMBER, 8'd0, 1'b0, acc_q,
						sline_q, scol_q, cfglex_pkg::ERR_NONE, 1'b1);
					mode_d = M_IDLE;
					again = 1'b1;
				end
			end
			M_WORD: begin
				e.a_valid = 1'b1;
				if (cont) begin
					newlen = len_q + cfglex_pkg::LenW'(1);
					if (newlen > LenLimit) begin
						e.a = cfglex_pkg::mk_res(cfglex_pkg::KIND_ERROR, 8'd0, 1'b0, 32'd0,
							line_q, col_q, cfglex_pkg::ERR_LONG, 1'b1);
						mode_d = M_HALT;
					end else begin
						e.a = cfglex_pkg::mk_res(cfglex_pkg::KIND_WORD, held_q, 1'b1, 32'd0,
							sline_q, scol_q, cfglex_pkg::ERR_NONE, 1'b0);
						held_d = c;
						len_d = newlen;
						col_d = sat_inc(col_q);
					end
				end else begin
					e.a = cfglex_pkg::mk_res(cfglex_pkg::KIND_WORD, held_q, 1'b1, 32'd0,
						sline_q, scol_q, cfglex_pkg::ERR_NONE, 1'b1);
					mode_d = M_IDLE;
					again = 1'b1;
				end
			end
			M_TEXT: begin
				if (c == cfglex_pkg::CH_QUOTE || c == cfglex_pkg::CH_NUL) begin
					e.a_valid = 1'b1;
					e.a = cfglex_pkg::mk_res(cfglex_pkg::KIND_TEXT, held_q, len_q != '0,
						32'd0, sline_q, scol_q, cfglex_pkg::ERR_NONE, 1'b1);
					if (len_q == '0) begin
						e.a.char_out = 8'd0;
					end
					mode_d = M_IDLE;
					if (c == cfglex_pkg::CH_NUL) begin
						again = 1'b1;
					end else begin
						col_d = sat_inc(col_q);
					end
				end else begin
					newlen = len_q + cfglex_pkg::LenW'(1);
					if (newlen > LenLimit) begin
						e.a_valid = 1'b1;
						e.a = cfglex_pkg::mk_res(cfglex_pkg::KIND_ERROR, 8'd0, 1'b0, 32'd0,
							line_q, col_q, cfglex_pkg::ERR_LONG, 1'b1);
						mode_d = M_HALT;
					end else begin
						e.a_valid = (len_q != '0);
						e.a = cfglex_pkg::mk_res(cfglex_pkg::KIND_TEXT, held_q, 1'b1, 32'd0,
							sline_q, scol_q, cfglex_pkg::ERR_NONE, 1'b0);
						held_d = c;
						len_d = newlen;
						col_d = sat_inc(col_q);
					end
				end
			end
			M_KW_TRUE, M_KW_FALSE: begin
				if (c == cfglex_pkg::kw_char(kw_is_false, pm)) begin
					col_d = sat_inc(col_q);
					if (pm + cfglex_pkg::RunW'(1) == kw_len) begin
						e.a_valid = 1'b1;
						e.a = cfglex_pkg::mk_res(kw_is_false ? cfglex_pkg::KIND_FALSE :
							cfglex_pkg::KIND_TRUE, 8'd0, 1'b0, 32'd0, sline_q, scol_q,
							cfglex_pkg::ERR_NONE, 1'b1);
						mode_d = M_IDLE;
						prefix_d = '0;
					end else begin
						prefix_d = pm + cfglex_pkg::RunW'(1);
					end
				end else begin
					newlen = cfglex_pkg::LenW'(pm) + cfglex_pkg::LenW'(cont);
					if (newlen > LenLimit) begin
						e.a_valid = 1'b1;
						e.a = cfglex_pkg::mk_res(cfglex_pkg::KIND_ERROR, 8'd0, 1'b0, 32'd0,
							line_q, col_q, cfglex_pkg::ERR_LONG, 1'b1);
						mode_d = M_HALT;
					end else begin
						e.run_cnt = pm;
						e.run_false = kw_is_false;
						e.run_last = !cont;
						e.run_line = sline_q;
						e.run_col = scol_q;
						prefix_d = '0;
						if (cont) begin
							mode_d = M_WORD;
							held_d = c;
							len_d = newlen;
							col_d = sat_inc(col_q);
						end else begin
							mode_d = M_IDLE;
							again = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (again) begin
			sline_d = line_d;
			scol_d = col_d;
			if (c == cfglex_pkg::CH_NUL) begin
				e.b_valid = 1'b1;
				e.b = cfglex_pkg::mk_res(cfglex_pkg::KIND_EOF, 8'd0, 1'b0, 32'd0,
					line_d, col_d, cfglex_pkg::ERR_NONE, 1'b1);
			end else if (c == cfglex_pkg::CH_HASH) begin
				if (col_d != PosOne) begin
					e.b_valid = 1'b1;
					e.b = cfglex_pkg::mk_res(cfglex_pkg::KIND_ERROR, 8'd0, 1'b0, 32'd0,
						line_d, col_d, cfglex_pkg::ERR_HASH, 1'b1);
					mode_d = M_HALT;
				end else begin
					mode_d = M_COMMENT;
					col_d = sat_inc(col_d);
				end
			end else if (c == cfglex_pkg::CH_SPACE || c == cfglex_pkg::CH_TAB) begin
				col_d = sat_inc(col_d);
			end else if (c == cfglex_pkg::CH_LF) begin
				line_d = sat_inc(line_d);
				col_d = PosOne;
			end else if (c == cfglex_pkg::CH_EQUAL || c == cfglex_pkg::CH_DOT ||
				c == cfglex_pkg::CH_COMMA) begin
				e.b_valid = 1'b1;
				e.b = cfglex_pkg::mk_res((c == cfglex_pkg::CH_EQUAL) ? cfglex_pkg::KIND_EQ :
					(c == cfglex_pkg::CH_DOT) ? cfglex_pkg::KIND_DOT : cfglex_pkg::KIND_COMMA,
					8'd0, 1'b0, 32'd0, line_d, col_d, cfglex_pkg::ERR_NONE, 1'b1);
				col_d = sat_inc(col_d);
			end else if (c == cfglex_pkg::CH_LBRACK) begin
				mode_d = M_LBRACK;
				col_d = sat_inc(col_d);
			end else if (c == cfglex_pkg::CH_RBRACK) begin
				mode_d = M_RBRACK;
				col_d = sat_inc(col_d);
			end else if (c == cfglex_pkg::CH_QUOTE) begin
				mode_d = M_TEXT;
				len_d = '0;
				col_d = sat_inc(col_d);
			end else if (is_digit(c)) begin
				mode_d = M_NUMBER;
				acc_d = {28'd0, digit};
				col_d = sat_inc(col_d);
			end else if (c == cfglex_pkg::CH_LOWER_T || c == cfglex_pkg::CH_LOWER_F) begin
				mode_d = (c == cfglex_pkg::CH_LOWER_T) ? M_KW_TRUE : M_KW_FALSE;
				prefix_d = cfglex_pkg::RunW'(1);
				col_d = sat_inc(col_d);
			end else if (is_alpha(c)) begin
				mode_d = M_WORD;
				held_d = c;
				len_d = cfglex_pkg::LenW'(1);
				col_d = sat_inc(col_d);
			end else begin
				e.b_valid = 1'b1;
				e.b = cfglex_pkg::mk_res(cfglex_pkg::KIND_ERROR, 8'd0, 1'b0, 32'd0,
					line_d, col_d, cfglex_pkg::ERR_BYTE, 1'b1);
				mode_d = M_HALT;
			end
		end

		if (c == cfglex_pkg::CH_NUL) begin
			mode_d = M_IDLE;
			prefix_d = '0;
			len_d = '0;
			acc_d = '0;
			line_d = PosOne;
			col_d = PosOne;
			sline_d = PosOne;
			scol_d = PosOne;
			held_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			prefix_q <= '0;
			len_q <= '0;
			acc_q <= '0;
			line_q <= PosOne;
			col_q <= PosOne;
			sline_q <= PosOne;
			scol_q <= PosOne;
			held_q <= 8'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			prefix_q <= prefix_d;
			len_q <= len_d;
			acc_q <= acc_d;
			line_q <= line_d;
			col_q <= col_d;
			sline_q <= sline_d;
			scol_q <= scol_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/cfglex_queue.sv */
// Short queue of result entries between the lexer front end and the result sequencer.
`default_nettype none
module cfglex_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cfglex_pkg::entry_t wdata,
	output logic full,
	input logic pop,
	output logic not_empty,
	output cfglex_pkg::entry_t head
);

	cfglex_pkg::entry_t mem_q [cfglex_pkg::QueueDepth];
	logic [cfglex_pkg::PtrW-1:0] wptr_q, rptr_q;
	logic [cfglex_pkg::CntW-1:0] cnt_q;

	assign full = (cnt_q == cfglex_pkg::CntW'(cfglex_pkg::QueueDepth));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + cfglex_pkg::PtrW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + cfglex_pkg::PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + cfglex_pkg::CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - cfglex_pkg::CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/cfglex_back.sv */
// Result sequencer: unpacks each queued entry into token items, one per cycle while the token sink is ready.
`default_nettype none
module cfglex_back (
	input logic clk,
	input logic arst_n,
	input logic not_empty,
	input cfglex_pkg::entry_t head,
	output logic pop,
	cfglex_token_if.source tokens
);

	logic [cfglex_pkg::RunW-1:0] idx_q;
	logic a_done_q;
	cfglex_pkg::res_t out_q;
	logic out_valid_q;

	logic load;
	logic in_run;
	logic run_end;
	logic final_res;
	cfglex_pkg::res_t cur;

	always_comb begin
		in_run = idx_q < head.run_cnt;
		run_end = (idx_q + cfglex_pkg::RunW'(1) == head.run_cnt);
		if (in_run) begin
			cur = cfglex_pkg::mk_res(cfglex_pkg::KIND_WORD,
				cfglex_pkg::kw_char(head.run_false, idx_q), 1'b1, 32'd0, head.run_line,
				head.run_col, cfglex_pkg::ERR_NONE, head.run_last && run_end);
			final_res = run_end && !head.a_valid && !head.b_valid;
		end else if (head.a_valid && !a_done_q) begin
			cur = head.a;
			final_res = !head.b_valid;
		end else begin
			cur = head.b;
			final_res = 1'b1;
		end
	end

	assign load = not_empty && (!out_valid_q || tokens.ready);
	assign pop = load && final_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			a_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (final_res) begin
					idx_q <= '0;
					a_done_q <= 1'b0;
				end else if (in_run) begin
					idx_q <= idx_q + cfglex_pkg::RunW'(1);
				end else begin
					a_done_q <= 1'b1;
				end
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= cur;
		end
	end

	assign tokens.valid = out_valid_q;
	assign tokens.kind = out_q.kind;
	assign tokens.char_out = out_q.char_out;
	assign tokens.char_valid = out_q.char_valid;
	assign tokens.number_value = out_q.number_value;
	assign tokens.token_line = out_q.token_line;
	assign tokens.token_column = out_q.token_column;
	assign tokens.error_code = out_q.error_code;
	assign tokens.last = out_q.last;

endmodule
`default_nettype wire

/* hdl/config_text_lexer_core.sv */
// Top level of the config text lexer: front end, entry queue and result sequencer.
// The token items of a byte pass through the entry queue and then the output register.
// Throughput: one byte per cycle while each byte gives at most one token item and the
// token sink is ready; a byte that gives more items sends them in turn, and a four-entry
// queue absorbs the difference. Asynchronous active-low reset returns to idle mode with
// line and column at 1 and empties the queue and output register.
`default_nettype none
module config_text_lexer_core (
	input logic clk,
	input logic arst_n,
	cfglex_byte_if.sink doc,
	cfglex_token_if.source tokens
);

	logic push;
	logic full;
	logic pop;
	logic not_empty;
	cfglex_pkg::entry_t entry;
	cfglex_pkg::entry_t head;

	cfglex_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.doc(doc),
		.full(full),
		.push(push),
		.entry(entry)
	);

	cfglex_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(entry),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.head(head)
	);

	cfglex_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.not_empty(not_empty),
		.head(head),
		.pop(pop),
		.tokens(tokens)
	);

endmodule
`default_nettype wire
